// ----- sv/nzte_pkg.sv -----
// ----------------------------------------------------------------------------
// nzte_pkg
// shared constants for the zda time extractor: characters, line layout,
// calendar constants and widths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nzte_pkg;

  localparam int OFFSET_W = 18;
  localparam int EPOCH_W  = 39;
  localparam int ACC_W    = 40;

  localparam int ZDA_LENGTH = 36;
  localparam int TAG_LEN    = 6;
  localparam int HOLD_DEPTH = 27;

  localparam logic [8*TAG_LEN-1:0] ZDA_TAG = "$GPZDA";

  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam int POS_HOUR = 7;
  localparam int POS_MIN  = 9;
  localparam int POS_SEC  = 11;
  localparam int POS_DAY  = 17;
  localparam int POS_MON  = 20;
  localparam int POS_YEAR = 23;

  localparam int DAYS_PER_ERA    = 146097;
  localparam int DAYS_PER_YEAR   = 365;
  localparam int EPOCH_DAY_SHIFT = 719469;
  localparam int SECS_PER_DAY    = 86400;
  localparam int SECS_PER_HOUR   = 3600;
  localparam int SECS_PER_MIN    = 60;

  // day of the march-based year at which each month starts
  function automatic logic [8:0] month_day_ofs(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- sv/nmea_zda_time_extractor.sv -----
// ----------------------------------------------------------------------------
// nmea_zda_time_extractor
// picks $GPZDA sentences out of a serial byte stream and converts the time
// fields to epoch seconds plus a programmable utc offset
//
// input channel: in_valid / in_stall / in_byte, one character per request.
// result channel: out_valid / out_stall, out_length_ok, out_epoch_seconds.
// config: cfg_wr_en writes cfg_wr_data into the utc offset register.
// ordinary characters and '$' are taken back to back.
// a CR or LF ending a ZDA line of 36 characters runs the time conversion:
// field decode and calendar prep in the PARSE, NORM, ERA and YOE states,
// 10 passes through one shared multiply-accumulate unit and the DONE state,
// which loads the result once the output register is free; then the next
// character can be taken.
// a ZDA line of another length skips conversion; its result has length_ok
// low and zero time. in_stall is high while a conversion runs or a result
// waits for the output register.
// a stalled result holds, and further characters are still taken while it
// waits. CR LF gives two results.
// reset clears the line count, the offset and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_zda_time_extractor #(
  parameter int LINE_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_byte,
  input  logic                                 cfg_wr_en,
  input  logic signed [nzte_pkg::OFFSET_W-1:0] cfg_wr_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_length_ok,
  output logic signed [nzte_pkg::EPOCH_W-1:0]  out_epoch_seconds
);
  import nzte_pkg::*;

  localparam int IDX_W      = $clog2(LINE_DEPTH + 1);
  localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PARSE, ST_NORM, ST_ERA, ST_YOE, ST_MAC, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    MS_ERA, MS_YOE, MS_YOE_Q4, MS_YOE_C100, MS_DOY, MS_MDAY,
    MS_DAYS, MS_HOUR, MS_MIN, MS_SEC
  } mac_step_t;

  typedef enum logic [1:0] {PH_BLANK, PH_DIGITS, PH_END} parse_ph_t;

  state_t                     state_r;
  logic [IDX_W-1:0]           wr_idx_r;
  logic signed [OFFSET_W-1:0] offset_r;
  logic                       out_valid_r;
  logic                       out_ok_r;
  logic signed [EPOCH_W-1:0]  out_epoch_r;

  logic [7:0]                 line_r [HOLD_DEPTH];
  logic signed [14:0]         year_r;
  logic signed [7:0]          mon0_r;
  logic signed [7:0]          mday_r;
  logic signed [7:0]          hour_r;
  logic signed [7:0]          min_r;
  logic signed [7:0]          sec_r;
  logic signed [14:0]         y_r;
  logic [3:0]                 mp_r;
  logic signed [5:0]          era_r;
  logic [8:0]                 doy_r;
  logic [8:0]                 yoe_r;
  logic [1:0]                 c100_r;
  mac_step_t                  step_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [23:0]         days_r;
  logic                       res_ok_r;
  logic signed [EPOCH_W-1:0]  res_epoch_r;

  logic                       in_accept;
  logic                       is_term;
  logic                       is_dollar;
  logic                       tag_ok;
  logic                       len_ok;
  logic                       out_free;

  logic signed [14:0]         f_year;
  logic signed [14:0]         f_mon;
  logic signed [14:0]         f_day;
  logic signed [14:0]         f_hour;
  logic signed [14:0]         f_min;
  logic signed [14:0]         f_sec;

  logic signed [4:0]          carry;
  logic signed [7:0]          mon_tmp;
  logic [3:0]                 month;
  logic signed [14:0]         y_nxt;
  logic [3:0]                 mp_nxt;

  logic [13:0]                era_in;
  logic [15:0]                era_prod;
  logic signed [5:0]          era_nxt;
  logic signed [14:0]         era_x400;
  logic signed [14:0]         yoe_full;
  logic [1:0]                 c100_nxt;

  logic signed [23:0]         mac_op;
  logic signed [18:0]         mac_k;
  logic signed [42:0]         mac_prod;
  logic signed [ACC_W-1:0]    acc_sum;

  function automatic logic signed [14:0] parse_field(input logic [31:0] chars,
                                                     input logic [2:0]  len);
    logic [13:0] v;
    logic        neg;
    parse_ph_t   ph;
    logic [7:0]  c;
    v   = '0;
    neg = 1'b0;
    ph  = PH_BLANK;
    for (int i = 0; i < 4; i++) begin
      c = chars[31-8*i -: 8];
      if (3'(i) < len) begin
        unique case (ph)
          PH_BLANK: begin
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
              ph = PH_BLANK;
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
              neg = (c == CHAR_MINUS);
              ph  = PH_DIGITS;
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
              v  = 14'(c - CHAR_ZERO);
              ph = PH_DIGITS;
            end else begin
              ph = PH_END;
            end
          end
          PH_DIGITS: begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
              v = 14'(v * 14'd10 + 14'(c - CHAR_ZERO));
            end else begin
              ph = PH_END;
            end
          end
          default: ph = PH_END;
        endcase
      end
    end
    return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  assign in_stall          = (state_r != ST_IDLE);
  assign in_accept         = in_valid && !in_stall;
  assign is_term           = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
  assign is_dollar         = (in_byte == CHAR_DOLLAR);
  assign len_ok            = (wr_idx_r == IDX_W'(ZDA_LENGTH));
  assign out_free          = !out_valid_r || !out_stall;
  assign out_valid         = out_valid_r;
  assign out_length_ok     = out_ok_r;
  assign out_epoch_seconds = out_epoch_r;

  always_comb begin
    tag_ok = (wr_idx_r >= IDX_W'(TAG_LEN));
    for (int i = 0; i < TAG_LEN; i++) begin
      if (line_r[i] != ZDA_TAG[8*TAG_LEN-1-8*i -: 8]) begin
        tag_ok = 1'b0;
      end
    end
  end

  // field decode
  always_comb begin
    f_year = parse_field({line_r[POS_YEAR], line_r[POS_YEAR+1],
                          line_r[POS_YEAR+2], line_r[POS_YEAR+3]}, 3'd4);
    f_mon  = parse_field({line_r[POS_MON], line_r[POS_MON+1], 16'h0}, 3'd2);
    f_day  = parse_field({line_r[POS_DAY], line_r[POS_DAY+1], 16'h0}, 3'd2);
    f_hour = parse_field({line_r[POS_HOUR], line_r[POS_HOUR+1], 16'h0}, 3'd2);
    f_min  = parse_field({line_r[POS_MIN], line_r[POS_MIN+1], 16'h0}, 3'd2);
    f_sec  = parse_field({line_r[POS_SEC], line_r[POS_SEC+1], 16'h0}, 3'd2);
  end

  // month overflow into the year, march-based month
  always_comb begin
    carry   = '0;
    mon_tmp = mon0_r + 8'sd1;
    if (mon0_r < 0) begin
      carry   = -5'sd1;
      mon_tmp = mon0_r + 8'sd13;
    end else begin
      for (int k = 1; k <= 8; k++) begin
        if (mon0_r >= 8'(12 * k)) begin
          carry   = 5'(k);
          mon_tmp = mon0_r - 8'(12 * k) + 8'sd1;
        end
      end
    end
    month  = mon_tmp[3:0];
    y_nxt  = year_r + 15'(carry) - 15'((month <= 4'd2) ? 1 : 0);
    mp_nxt = (month > 4'd2) ? month - 4'd3 : month + 4'd9;
  end

  // era = floor(y / 400) through (y + 1200) / 16 * 41 / 1024 - 3
  always_comb begin
    era_in   = 14'(y_r + 15'sd1200);
    era_prod = 16'(era_in[13:4]) * 16'd41;
    era_nxt  = $signed(6'(era_prod[15:10] - 6'd3));
    era_x400 = 15'(era_r) * 15'sd400;
    yoe_full = y_r - era_x400;
    if (yoe_full >= 15'sd300) begin
      c100_nxt = 2'd3;
    end else if (yoe_full >= 15'sd200) begin
      c100_nxt = 2'd2;
    end else if (yoe_full >= 15'sd100) begin
      c100_nxt = 2'd1;
    end else begin
      c100_nxt = 2'd0;
    end
  end

  // shared multiply-accumulate unit
  always_comb begin
    unique case (step_r)
      MS_ERA: begin
        mac_op = 24'(era_r);
        mac_k  = 19'(DAYS_PER_ERA);
      end
      MS_YOE: begin
        mac_op = 24'(yoe_r);
        mac_k  = 19'(DAYS_PER_YEAR);
      end
      MS_YOE_Q4: begin
        mac_op = 24'(yoe_r[8:2]);
        mac_k  = 19'sd1;
      end
      MS_YOE_C100: begin
        mac_op = 24'(c100_r);
        mac_k  = -19'sd1;
      end
      MS_DOY: begin
        mac_op = 24'(doy_r);
        mac_k  = 19'sd1;
      end
      MS_MDAY: begin
        mac_op = 24'(mday_r);
        mac_k  = 19'sd1;
      end
      MS_DAYS: begin
        mac_op = days_r;
        mac_k  = 19'(SECS_PER_DAY);
      end
      MS_HOUR: begin
        mac_op = 24'(hour_r);
        mac_k  = 19'(SECS_PER_HOUR);
      end
      MS_MIN: begin
        mac_op = 24'(min_r);
        mac_k  = 19'(SECS_PER_MIN);
      end
      MS_SEC: begin
        mac_op = 24'(sec_r);
        mac_k  = 19'sd1;
      end
      default: begin
        mac_op = '0;
        mac_k  = '0;
      end
    endcase
    mac_prod = mac_op * mac_k;
    acc_sum  = acc_r + ACC_W'(mac_prod);
  end

  // sequencer, line count, offset register and result channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_idx_r    <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            if (is_term) begin
              if (tag_ok) begin
                state_r <= len_ok ? ST_PARSE : ST_DONE;
              end
            end else if (is_dollar) begin
              wr_idx_r <= IDX_W'(1);
            end else if (wr_idx_r < IDX_W'(LINE_DEPTH)) begin
              wr_idx_r <= wr_idx_r + 1'b1;
            end
          end
        end
        ST_PARSE: state_r <= ST_NORM;
        ST_NORM:  state_r <= ST_ERA;
        ST_ERA:   state_r <= ST_YOE;
        ST_YOE:   state_r <= ST_MAC;
        ST_MAC: begin
          if (step_r == MS_SEC) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= res_ok_r;
            out_epoch_r <= res_epoch_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // line store and conversion datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (is_term) begin
            res_ok_r    <= 1'b0;
            res_epoch_r <= '0;
          end else if (is_dollar) begin
            line_r[0] <= CHAR_DOLLAR;
          end else if (wr_idx_r < IDX_W'(HOLD_DEPTH)) begin
            line_r[wr_idx_r[HOLD_IDX_W-1:0]] <= in_byte;
          end
        end
      end
      ST_PARSE: begin
        year_r <= f_year;
        mon0_r <= f_mon[7:0] - 8'sd1;
        mday_r <= f_day[7:0];
        hour_r <= f_hour[7:0];
        min_r  <= f_min[7:0];
        sec_r  <= f_sec[7:0];
      end
      ST_NORM: begin
        y_r  <= y_nxt;
        mp_r <= mp_nxt;
      end
      ST_ERA: begin
        era_r <= era_nxt;
        doy_r <= month_day_ofs(mp_r);
      end
      ST_YOE: begin
        yoe_r  <= yoe_full[8:0];
        c100_r <= c100_nxt;
        step_r <= MS_ERA;
        acc_r  <= -ACC_W'(EPOCH_DAY_SHIFT);
      end
      ST_MAC: begin
        step_r <= mac_step_t'(step_r + 4'd1);
        if (step_r == MS_MDAY) begin
          days_r <= acc_sum[23:0];
          acc_r  <= ACC_W'(offset_r);
        end else begin
          acc_r <= acc_sum;
        end
        if (step_r == MS_SEC) begin
          res_ok_r    <= 1'b1;
          res_epoch_r <= acc_sum[EPOCH_W-1:0];
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/nzte_checker.sv -----
// ----------------------------------------------------------------------------
// nzte_checker
// port-level checks on the result channel of the zda time extractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nzte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_length_ok,
  input logic [38:0] out_epoch_seconds
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_length_ok)
      && $stable(out_epoch_seconds))
    else $error("result changed while stalled");

  // a line of the wrong length reports zero time
  a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_length_ok |-> out_epoch_seconds == '0)
    else $error("nonzero time with length_ok low");

  // reset empties the result channel
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a new result is only loaded while the input side is held off
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a conversion");

endmodule

bind nmea_zda_time_extractor nzte_checker u_nzte_checker (.*);

// ----- sim/nmea_zda_time_extractor_tb.sv -----
// ----------------------------------------------------------------------------
// nmea_zda_time_extractor_tb
// serial characters into the zda time extractor: hand-written sentences,
// then random sentences under several utc offsets, random input gaps and
// random result stalls, each result checked against a line-store model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_zda_time_extractor_tb;

  import nzte_pkg::*;

  localparam int LINE_DEPTH     = 64;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LINES_PER_SET  = 3;
  localparam longint EPOCH_DAYS = 719468;

  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;

  typedef enum int {
    TERM_CRLF,
    TERM_LF,
    TERM_CR,
    TERM_NONE
  } line_term_t;

  typedef struct packed {
    logic               length_ok;
    logic [EPOCH_W-1:0] epoch;
  } zda_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_byte = 8'h00;
  logic                       cfg_wr_en = 1'b0;
  logic signed [OFFSET_W-1:0] cfg_wr_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_length_ok;
  logic signed [EPOCH_W-1:0]  out_epoch_seconds;

  // line store model
  logic [7:0]  line_buf [LINE_DEPTH];
  int unsigned line_len;
  longint      utc_ofs;

  logic [7:0]  serial_bytes[$];
  logic [7:0]  line_q[$];
  zda_result_t expected_times[$];

  int          burst_left;
  int          gap_left;
  int          stall_mode;
  int          stall_run;
  int          stall_clock;
  int          idle_cycles;
  int unsigned error_count;
  int          phase_offsets[6] = '{-86400, 86400, -131072, 131071, 0, 0};

  nmea_zda_time_extractor uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_length_ok     (out_length_ok),
    .out_epoch_seconds (out_epoch_seconds)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic longint div_floor(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint field_value(input int pos, input int len);
    int     i;
    int     stop;
    longint v;
    bit     neg;
    i    = pos;
    stop = pos + len;
    v    = 0;
    neg  = 1'b0;
    while (i < stop && (line_buf[i] == CHAR_SPACE ||
                        (line_buf[i] >= CHAR_TAB && line_buf[i] <= CHAR_CR)))
      i++;
    if (i < stop && (line_buf[i] == CHAR_PLUS || line_buf[i] == CHAR_MINUS)) begin
      neg = (line_buf[i] == CHAR_MINUS);
      i++;
    end
    while (i < stop && line_buf[i] >= CHAR_ZERO && line_buf[i] <= CHAR_NINE) begin
      v = v * 10 + longint'(line_buf[i]) - longint'(CHAR_ZERO);
      i++;
    end
    return neg ? -v : v;
  endfunction

  // days from 1970-01-01 to the first day of month m of year y
  function automatic longint days_before_month(input longint y, input longint m);
    longint era;
    longint yoe;
    longint doy;
    longint doe;
    if (m <= 2) y--;
    era = div_floor(y, 400);
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5;
    doe = yoe * DAYS_PER_YEAR + yoe / 4 - yoe / 100 + doy;
    return era * DAYS_PER_ERA + doe - EPOCH_DAYS;
  endfunction

  function automatic longint line_epoch();
    longint year;
    longint mon0;
    longint mday;
    longint hour;
    longint minute;
    longint sec;
    longint carry;
    longint days;
    year   = field_value(POS_YEAR, 4);
    mon0   = field_value(POS_MON, 2) - 1;
    mday   = field_value(POS_DAY, 2);
    hour   = field_value(POS_HOUR, 2);
    minute = field_value(POS_MIN, 2);
    sec    = field_value(POS_SEC, 2);
    carry  = div_floor(mon0, 12);
    year   = year + carry;
    mon0   = mon0 - carry * 12;
    days   = days_before_month(year, mon0 + 1) + mday - 1;
    return days * SECS_PER_DAY + hour * SECS_PER_HOUR + minute * SECS_PER_MIN + sec + utc_ofs;
  endfunction

  function automatic bit line_has_zda_tag();
    int k;
    for (k = 0; k < TAG_LEN; k++)
      if (line_buf[k] != ZDA_TAG[8*(TAG_LEN-1-k) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void track_char(input logic [7:0] c);
    zda_result_t r;
    if (c == CHAR_CR || c == CHAR_LF) begin
      if (line_len >= TAG_LEN && line_has_zda_tag()) begin
        r.length_ok = (line_len == ZDA_LENGTH);
        r.epoch     = r.length_ok ? EPOCH_W'(line_epoch()) : '0;
        expected_times.push_back(r);
      end
    end else if (c == CHAR_DOLLAR) begin
      foreach (line_buf[k]) line_buf[k] = 8'h00;
      line_buf[0] = c;
      line_len    = 1;
    end else if (line_len < LINE_DEPTH) begin
      line_buf[line_len] = c;
      line_len++;
    end
  endfunction

  // ---------------------------------------------------------------- sentence building

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void start_zda(input int hh, input int mi, input int ss,
                                    input int dd, input int mo, input int yr);
    line_q.delete();
    add_text($sformatf("$GPZDA,%02d%02d%02d.00,%02d,%02d,%04d,00,00*%02X",
                       hh, mi, ss, dd, mo, yr, $urandom_range(0, 255)));
  endfunction

  function automatic void end_line(input line_term_t term);
    case (term)
      TERM_CRLF: begin
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);
      end
      TERM_LF:   line_q.push_back(CHAR_LF);
      TERM_CR:   line_q.push_back(CHAR_CR);
      default:   ;
    endcase
    foreach (line_q[k]) serial_bytes.push_back(line_q[k]);
    line_q.delete();
  endfunction

  function automatic logic [7:0] odd_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = CHAR_SPACE;
      1: c = CHAR_TAB;
      2: c = $urandom_range(0, 1) ? CHAR_VT : CHAR_FF;
      3: c = CHAR_PLUS;
      4: c = CHAR_MINUS;
      5: c = 8'h00;
      default: begin
        c = 8'($urandom_range(0, 255));
        while (c == CHAR_DOLLAR || c == CHAR_CR || c == CHAR_LF)
          c = 8'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  function automatic void random_line();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0)
      start_zda($urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 99),
                $urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 9999));
    else
      start_zda($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 60),
                $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1970, 2099));
    case (kind)
      6: line_q[$urandom_range(1, TAG_LEN - 1)] = odd_char();
      7: begin
        line_q.delete();
        repeat ($urandom_range(1, 40)) line_q.push_back(8'($urandom_range(0, 255)));
      end
      8: repeat ($urandom_range(1, 40)) line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      9: begin
        n = $urandom_range(1, ZDA_LENGTH - 1);
        while (line_q.size() > n) line_q.pop_back();
      end
      default: begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) line_q[$urandom_range(POS_HOUR, POS_YEAR + 3)] = odd_char();
        case ($urandom_range(0, 7))
          0: line_q.pop_back();
          1: line_q.push_back(CHAR_ZERO);
          default: ;
        endcase
      end
    endcase
    case ($urandom_range(0, 4))
      0, 1:    end_line(TERM_CRLF);
      2:       end_line(TERM_LF);
      3:       end_line(TERM_CR);
      default: end_line(TERM_NONE);
    endcase
  endfunction

  // ---------------------------------------------------------------- sequencing

  task automatic wait_idle();
    @(negedge clk);
    while (serial_bytes.size() != 0 || in_valid || in_stall || out_valid ||
           expected_times.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(input int value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= OFFSET_W'(value);
    utc_ofs      = longint'($signed(OFFSET_W'(value)));
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    foreach (line_buf[k]) line_buf[k] = 8'h00;
    line_len = 0;
    utc_ofs  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // line end on an empty store, then characters with no leading dollar
    end_line(TERM_LF);
    add_text("GPZDA");
    end_line(TERM_CR);

    // CR LF gives two results; a character after it lengthens the same line
    start_zda(20, 15, 30, 4, 7, 2002);
    end_line(TERM_CRLF);
    add_text("X");
    end_line(TERM_LF);

    start_zda(0, 0, 0, 1, 1, 1970);
    end_line(TERM_LF);
    start_zda(99, 99, 99, 99, 99, 9999);
    end_line(TERM_LF);
    start_zda(0, 0, 0, 0, 0, 0);
    end_line(TERM_CR);

    // signed fields
    start_zda(0, 0, 0, 1, 1, 2000);
    line_q[POS_HOUR] = CHAR_MINUS;
    line_q[POS_MIN]  = CHAR_PLUS;
    line_q[POS_DAY]  = CHAR_MINUS;
    line_q[POS_MON]  = CHAR_MINUS;
    line_q[POS_YEAR] = CHAR_MINUS;
    end_line(TERM_LF);

    // leading blanks and fields with no digit
    start_zda(12, 0, 0, 15, 6, 2024);
    line_q[POS_HOUR]     = CHAR_SPACE;
    line_q[POS_MIN]      = CHAR_TAB;
    line_q[POS_SEC]      = CHAR_VT;
    line_q[POS_SEC + 1]  = CHAR_FF;
    line_q[POS_DAY]      = CHAR_SPACE;
    line_q[POS_DAY + 1]  = CHAR_SPACE;
    line_q[POS_MON]      = CHAR_PLUS;
    line_q[POS_MON + 1]  = CHAR_SPACE;
    line_q[POS_YEAR]     = CHAR_SPACE;
    line_q[POS_YEAR + 1] = CHAR_PLUS;
    line_q[POS_YEAR + 2] = CHAR_SPACE;
    end_line(TERM_LF);

    // zero and high bytes inside the line
    start_zda(1, 2, 3, 4, 5, 2006);
    line_q[POS_HOUR + 1] = 8'h00;
    line_q[14]           = 8'hFF;
    line_q[33]           = 8'h80;
    end_line(TERM_LF);

    // tag alone, tag cut short, one short, store overrun, other sentence
    add_text("$GPZDA");
    end_line(TERM_LF);
    add_text("$GPZD");
    end_line(TERM_LF);
    start_zda(10, 20, 30, 11, 11, 2011);
    line_q.pop_back();
    end_line(TERM_CR);
    start_zda(10, 20, 30, 11, 11, 2011);
    repeat (40) line_q.push_back("A");
    end_line(TERM_LF);
    start_zda(10, 20, 30, 11, 11, 2011);
    line_q[3] = "R";
    end_line(TERM_LF);

    // dollar in the middle restarts the line
    add_text("$GPRMC,12");
    end_line(TERM_NONE);
    start_zda(23, 59, 59, 31, 12, 1999);
    end_line(TERM_CRLF);

    phase_offsets[4] = int'($urandom_range(0, 2 * SECS_PER_DAY)) - SECS_PER_DAY;
    phase_offsets[5] = int'($urandom_range(0, 2 * SECS_PER_DAY)) - SECS_PER_DAY;
    foreach (phase_offsets[p]) begin
      wait_idle();
      write_offset(phase_offsets[p]);
      repeat (LINES_PER_SET) random_line();
    end
    wait_idle();

    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- character driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) track_char(in_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (serial_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_byte  <= serial_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result monitor

  always @(posedge clk) begin : result_check
    zda_result_t want;
    bit          stall_next;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_times.size() == 0) begin
        $error("result with no request pending: length_ok=%0d epoch_seconds=%0d",
               out_length_ok, out_epoch_seconds);
        error_count++;
      end else begin
        want = expected_times.pop_front();
        if (out_length_ok !== want.length_ok) begin
          $error("length_ok: expected %0d, got %0d", want.length_ok, out_length_ok);
          error_count++;
        end
        if (out_epoch_seconds !== want.epoch) begin
          $error("epoch_seconds: expected %0d, got %0d",
                 $signed(want.epoch), out_epoch_seconds);
          error_count++;
        end
      end
    end

    stall_clock <= stall_clock + 1;
    if (stall_clock % 200 == 199) stall_mode <= $urandom_range(0, 2);

    stall_next = 1'b0;
    if (stall_run != 0) begin
      stall_next = 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      case (stall_mode)
        1: stall_next = 1'($urandom_range(0, 1));
        2: if ($urandom_range(0, 15) == 0) begin
          stall_next = 1'b1;
          stall_run <= $urandom_range(4, 30);
        end
        default: stall_next = 1'b0;
      endcase
    end
    out_stall <= stall_next;
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
